FILE: hw/rtl/hcd_pkg.sv
package hcd_pkg;

    localparam int LENGTH_BITS = 16;

    localparam logic [15:0] MAX_LEN_RESET = 16'd10000;

    localparam logic [2:0] PH_DIGITS = 3'd0;
    localparam logic [2:0] PH_EXT    = 3'd1;
    localparam logic [2:0] PH_HDR_LF = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_TRL_CR = 3'd4;
    localparam logic [2:0] PH_TRL_LF = 3'd5;

    localparam logic [1:0] KIND_BODY   = 2'd0;
    localparam logic [1:0] KIND_GOOD   = 2'd1;
    localparam logic [1:0] KIND_DROP   = 2'd2;
    localparam logic [1:0] KIND_HDRERR = 2'd3;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  body_byte;
        logic [15:0] error_total;
    } result_t;

endpackage

FILE: hw/rtl/hcd_parser.sv
module hcd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    output hcd_pkg::result_t   res
);

    localparam int LB = hcd_pkg::LENGTH_BITS;
    localparam int AW = LB + 1;
    localparam int CW = (AW > 16) ? AW : 16;
    localparam logic [LB+4:0] CAP_WIDE = (LB + 5)'(1) << LB;
    localparam logic [AW-1:0] CAP = AW'(1) << LB;

    logic [15:0]   max_len_reg;
    logic [2:0]    phase_reg, phase_next;
    logic [AW-1:0] accum_reg, accum_next;
    logic          digit_seen_reg, digit_seen_next;
    logic [AW-1:0] bytes_left_reg, bytes_left_next;
    logic [15:0]   error_count_reg, error_count_next;

    logic          is_hex;
    logic [3:0]    hex_val;
    logic [LB+4:0] accum_wide;
    logic          too_long;
    logic [15:0]   error_inc;

    always_comb begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
            hex_val = rx_byte[3:0];
        end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
                     (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
            hex_val = 4'(rx_byte[2:0] + 3'd1) + 4'd8;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign accum_wide = {accum_reg, 4'b0000} | (LB + 5)'(hex_val);
    assign too_long   = CW'(accum_reg) > CW'(max_len_reg);
    assign error_inc  = (error_count_reg != 16'hFFFF) ? error_count_reg + 16'd1
                                                      : error_count_reg;

    always_comb begin
        phase_next       = phase_reg;
        accum_next       = accum_reg;
        digit_seen_next  = digit_seen_reg;
        bytes_left_next  = bytes_left_reg;
        error_count_next = error_count_reg;
        res_valid        = 1'b0;
        res.kind         = hcd_pkg::KIND_BODY;
        res.body_byte    = 8'd0;
        res.error_total  = error_count_reg;

        unique case (phase_reg)
            hcd_pkg::PH_DIGITS: begin
                if (is_hex) begin
                    accum_next      = (accum_wide > CAP_WIDE) ? CAP : AW'(accum_wide);
                    digit_seen_next = 1'b1;
                end else if (rx_byte == hcd_pkg::CH_CR) begin
                    phase_next = hcd_pkg::PH_HDR_LF;
                end else begin
                    phase_next = hcd_pkg::PH_EXT;
                end
            end
            hcd_pkg::PH_EXT: begin
                if (rx_byte == hcd_pkg::CH_CR) begin
                    phase_next = hcd_pkg::PH_HDR_LF;
                end
            end
            hcd_pkg::PH_HDR_LF: begin
                if (rx_byte == hcd_pkg::CH_CR) begin
                    phase_next = hcd_pkg::PH_HDR_LF;
                end else if (rx_byte != hcd_pkg::CH_LF) begin
                    phase_next = hcd_pkg::PH_EXT;
                end else if (!digit_seen_reg || too_long) begin
                    error_count_next = error_inc;
                    res_valid        = 1'b1;
                    res.kind         = hcd_pkg::KIND_HDRERR;
                    res.error_total  = error_inc;
                    phase_next       = hcd_pkg::PH_DIGITS;
                    accum_next       = '0;
                    digit_seen_next  = 1'b0;
                    bytes_left_next  = '0;
                end else begin
                    bytes_left_next = accum_reg;
                    phase_next = (accum_reg == '0) ? hcd_pkg::PH_TRL_CR : hcd_pkg::PH_BODY;
                end
            end
            hcd_pkg::PH_BODY: begin
                bytes_left_next = bytes_left_reg - AW'(1);
                if (bytes_left_reg == AW'(1)) begin
                    phase_next = hcd_pkg::PH_TRL_CR;
                end
                res_valid     = 1'b1;
                res.kind      = hcd_pkg::KIND_BODY;
                res.body_byte = rx_byte;
            end
            hcd_pkg::PH_TRL_CR: begin
                if (rx_byte == hcd_pkg::CH_CR) begin
                    phase_next = hcd_pkg::PH_TRL_LF;
                end else begin
                    res_valid       = 1'b1;
                    res.kind        = hcd_pkg::KIND_DROP;
                    phase_next      = hcd_pkg::PH_DIGITS;
                    accum_next      = '0;
                    digit_seen_next = 1'b0;
                    bytes_left_next = '0;
                end
            end
            hcd_pkg::PH_TRL_LF: begin
                res_valid       = 1'b1;
                res.kind        = (rx_byte == hcd_pkg::CH_LF) ? hcd_pkg::KIND_GOOD
                                                              : hcd_pkg::KIND_DROP;
                phase_next      = hcd_pkg::PH_DIGITS;
                accum_next      = '0;
                digit_seen_next = 1'b0;
                bytes_left_next = '0;
            end
            default: begin
                phase_next      = hcd_pkg::PH_DIGITS;
                accum_next      = '0;
                digit_seen_next = 1'b0;
                bytes_left_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg     <= hcd_pkg::MAX_LEN_RESET;
            phase_reg       <= hcd_pkg::PH_DIGITS;
            accum_reg       <= '0;
            digit_seen_reg  <= 1'b0;
            bytes_left_reg  <= '0;
            error_count_reg <= '0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg       <= phase_next;
                accum_reg       <= accum_next;
                digit_seen_reg  <= digit_seen_next;
                bytes_left_reg  <= bytes_left_next;
                error_count_reg <= error_count_next;
            end
        end
    end

    // body phase is entered only with a nonzero count
    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == hcd_pkg::PH_BODY |-> bytes_left_reg != '0)
        else $error("body phase with zero bytes left");

    a_err_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> error_count_reg >= $past(error_count_reg))
        else $error("error count went down");

    a_hdrerr_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid && res.kind == hcd_pkg::KIND_HDRERR
        |=> phase_reg == hcd_pkg::PH_DIGITS && !digit_seen_reg && accum_reg == '0)
        else $error("header error did not restart the hunt");

endmodule

FILE: hw/rtl/hcd_out_reg.sv
module hcd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  hcd_pkg::result_t load_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hcd_pkg::result_t out_data
);

    logic             valid_reg, valid_next;
    hcd_pkg::result_t data_reg;

    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/http_chunk_deframer_top.sv
// A result appears on the master side in the cycle after the byte that causes it.
// One byte per cycle unless m_tready stalls; the single output register refills as it drains.
// Bytes that cause no result (header, trailer CR) only advance the parser state.
// Reset: aresetn is synchronous, active low; it restores the header hunt, clears
// the error counter and the output valid flag, and sets max_chunk_length to 10000.
module http_chunk_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max_chunk_length
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] body_byte, [23:8] error_total
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic             accept;
    logic             res_valid;
    hcd_pkg::result_t res;
    hcd_pkg::result_t out_data;

    // Take a new request whenever the output slot is empty or drains this cycle.
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Parser: one state update per accepted byte, result decided in the same cycle.
    hcd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: load only when the accepted byte produces a result.
    hcd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && res_valid),
        .load_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tuser = out_data.kind;
    assign m_tdata = {out_data.error_total, out_data.body_byte};

endmodule
